[design/bts_pkg.sv]
// ----------------------------------------------------------------------------
// bts_pkg
// Shared types and constants of the bilinear RGB8 texture sampler.
// ----------------------------------------------------------------------------
package bts_pkg;

  // Default sizes of the texel store and of one texture side.
  localparam int unsigned MAX_TEXELS_DEFAULT = 65536;
  localparam int unsigned MAX_SIDE_DEFAULT   = 256;

  // Field widths of the stream items.
  localparam int unsigned CH_W       = 8;
  localparam int unsigned CHANNELS   = 3;
  localparam int unsigned TEXEL_W    = CH_W * CHANNELS;
  localparam int unsigned COORD_W    = 16;
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned IN_DATA_W  = ADDR_W + TEXEL_W + 2 * COORD_W;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = 2'd1;

  // Side value after reset, before saturation to the configured maximum.
  localparam int unsigned TEX_SIDE_RESET = 256;

  // Item kinds carried in tuser.
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;

  // Fixed point constants: 1.0 in 0.16 coordinates, 1.0 in 8-bit weights,
  // and one half of the final 16-bit fraction for rounding.
  localparam logic [COORD_W:0] COORD_ONE  = 17'h1_0000;
  localparam logic [8:0]       WEIGHT_ONE = 9'd256;
  localparam logic [23:0]      ROUND_HALF = 24'd32768;

  typedef logic [TEXEL_W-1:0] texel_t;

  // Texel order: 0 = (x0,y0), 1 = (x1,y0), 2 = (x0,y1), 3 = (x1,y1).
  typedef struct packed {
    logic [7:0]   fx;
    logic [7:0]   fy;
    texel_t [3:0] texel;
  } blend_req_t;

endpackage

[design/bts_blend.sv]
// ----------------------------------------------------------------------------
// bts_blend
// Two-stage bilinear blend of four RGB8 texels with 8-bit weights.
// ----------------------------------------------------------------------------
module bts_blend (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  bts_pkg::blend_req_t req_i,
  output logic               done_o,
  output bts_pkg::texel_t    color_o
);
  import bts_pkg::*;

  logic [15:0] lo_d [CHANNELS];
  logic [15:0] hi_d [CHANNELS];
  logic [15:0] lo_q [CHANNELS];
  logic [15:0] hi_q [CHANNELS];
  logic [7:0]  fy_q;
  logic        s1_valid_q;
  logic        s2_valid_q;
  texel_t      color_d;
  texel_t      color_q;

  // Stage one blends along x within the upper and lower rows.
  always_comb begin
    logic [8:0]  wx0;
    logic [16:0] a;
    logic [16:0] b;
    logic [16:0] c;
    logic [16:0] d;
    wx0 = WEIGHT_ONE - {1'b0, req_i.fx};
    for (int k = 0; k < CHANNELS; k++) begin
      a = 17'(req_i.texel[0][k*CH_W +: CH_W]) * 17'(wx0);
      b = 17'(req_i.texel[1][k*CH_W +: CH_W]) * 17'(req_i.fx);
      c = 17'(req_i.texel[2][k*CH_W +: CH_W]) * 17'(wx0);
      d = 17'(req_i.texel[3][k*CH_W +: CH_W]) * 17'(req_i.fx);
      lo_d[k] = 16'(a + b);
      hi_d[k] = 16'(c + d);
    end
  end

  // Stage two blends the rows along y and rounds to nearest.
  always_comb begin
    logic [8:0]  wy0;
    logic [23:0] sum;
    wy0 = WEIGHT_ONE - {1'b0, fy_q};
    for (int k = 0; k < CHANNELS; k++) begin
      sum = 24'(lo_q[k]) * 24'(wy0) + 24'(hi_q[k]) * 24'(fy_q) + ROUND_HALF;
      color_d[k*CH_W +: CH_W] = sum[23:16];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      lo_q <= lo_d;
      hi_q <= hi_d;
      fy_q <= req_i.fy;
    end
    if (s1_valid_q) begin
      color_q <= color_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  assign done_o  = s2_valid_q;
  assign color_o = color_q;

endmodule

[design/bilinear_texture_sampler_rgb.sv]
// ----------------------------------------------------------------------------
// bilinear_texture_sampler_rgb
// RGB8 texture store with a bilinear sampler at unsigned 0.16 coordinates.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                      Payload
// s_axis    in         s_axis_tvalid_i/tready_o       tuser = mode, tdata = write/sample
// m_axis    out        m_axis_tvalid_o/tready_i       tdata = filtered RGB8 color
// cfg       in         cfg_valid_i/cfg_ready_o        cfg_index_i, cfg_data_i
//
// A write transaction completes at acceptance: the texel goes into the store in the
// cycle it is accepted. A sample transaction occupies the block through accept,
// coordinate setup, four reads through the single read port of the texel memory,
// collecting the last texel, two blend stages and loading the output register,
// in that order. The output register lets the next transaction enter while a
// result waits; a sample only stalls in its last step when the previous result
// has not yet been taken.
// Reset clears control state and the size registers (256 by 256, saturated);
// the texel store is not cleared and must be written before it is sampled.
//
module bilinear_texture_sampler_rgb #(
  parameter int unsigned MAX_TEXELS = bts_pkg::MAX_TEXELS_DEFAULT,
  parameter int unsigned MAX_SIDE   = bts_pkg::MAX_SIDE_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input items.
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // tdata from bit 0 up: texel_address[15:0], texel_red[7:0], texel_green[7:0],
  // texel_blue[7:0], coord_u[15:0], coord_v[15:0].
  input  logic [bts_pkg::IN_DATA_W-1:0] s_axis_tdata_i,
  // tuser: mode (0 = write texel, 1 = sample).
  input  logic                          s_axis_tuser_i,
  // Result items.
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // tdata from bit 0 up: out_red[7:0], out_green[7:0], out_blue[7:0].
  output logic [bts_pkg::TEXEL_W-1:0]   m_axis_tdata_o,
  // Configuration writes.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bts_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bts_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import bts_pkg::*;

  // Width of a saturated side, of a store address and of a linear index.
  localparam int unsigned SW = $clog2(MAX_SIDE + 1);
  localparam int unsigned AW = (MAX_TEXELS > 1) ? $clog2(MAX_TEXELS) : 1;
  localparam int unsigned IW = 2 * SW;
  localparam int unsigned SideReset =
    (TEX_SIDE_RESET > MAX_SIDE) ? MAX_SIDE : TEX_SIDE_RESET;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_COORD = 6'b000010,
    S_READ  = 6'b000100,
    S_LAST  = 6'b001000,
    S_BLEND = 6'b010000,
    S_EMIT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Unpacked input fields.
  logic [ADDR_W-1:0]  in_addr;
  texel_t             in_texel;
  logic [COORD_W-1:0] in_u;
  logic [COORD_W-1:0] in_v;

  assign in_addr  = s_axis_tdata_i[ADDR_W-1:0];
  assign in_texel = s_axis_tdata_i[ADDR_W +: TEXEL_W];
  assign in_u     = s_axis_tdata_i[ADDR_W + TEXEL_W +: COORD_W];
  assign in_v     = s_axis_tdata_i[ADDR_W + TEXEL_W + COORD_W +: COORD_W];

  logic s_fire;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  // ---------------------------------------------------------------------------
  // Size registers. They hold the side already forced into 1..MAX_SIDE.
  // ---------------------------------------------------------------------------
  logic [SW-1:0] width_q;
  logic [SW-1:0] height_q;
  logic [SW-1:0] cfg_side;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    if (cfg_data_i == '0) begin
      cfg_side = SW'(1);
    end else if (32'(cfg_data_i) > 32'(MAX_SIDE)) begin
      cfg_side = SW'(MAX_SIDE);
    end else begin
      cfg_side = SW'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SW'(SideReset);
      height_q <= SW'(SideReset);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_TEX_WIDTH:  width_q  <= cfg_side;
        REG_TEX_HEIGHT: height_q <= cfg_side;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Texel store: one write port used at accept, one read port used by the
  // sampler. The two never operate in the same cycle.
  // ---------------------------------------------------------------------------
  texel_t mem [MAX_TEXELS];
  texel_t rdata_q;
  logic   mem_we;
  logic   mem_re;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [31:0]   waddr_ext;

  assign waddr_ext = 32'(in_addr);
  assign mem_waddr = waddr_ext[AW-1:0];
  // Writes beyond the store are dropped.
  assign mem_we = s_fire && (s_axis_tuser_i == MODE_WRITE) &&
                  (waddr_ext < 32'(MAX_TEXELS));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= in_texel;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // ---------------------------------------------------------------------------
  // Sample datapath.
  // ---------------------------------------------------------------------------
  // Scaled coordinates, SW.16 for x and (SW+1).16 for y: x = u*W, y = (1-v)*H.
  logic [COORD_W+SW-1:0] xf_q;
  logic [COORD_W+SW:0]   yf_q;

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      xf_q <= (COORD_W+SW)'(in_u) * (COORD_W+SW)'(width_q);
      yf_q <= (COORD_W+SW+1)'(COORD_ONE - {1'b0, in_v}) * (COORD_W+SW+1)'(height_q);
    end
  end

  // Neighbor coordinates with clamping at the far edges, and row bases.
  logic [SW-1:0] x0_raw, y0_raw;
  logic [SW-1:0] x0_c, y0_c, x1_c, y1_c;
  logic [SW:0]   x0_inc, y0_inc;
  logic [SW-1:0] x0_q, x1_q;
  logic [IW-1:0] base0_q, base1_q;
  logic [7:0]    fx_q, fy_q;

  assign x0_raw = xf_q[COORD_W +: SW];
  assign y0_raw = yf_q[COORD_W +: SW];

  always_comb begin
    // Only v = 0 can put the row on the side itself; x always stays below it.
    x0_c   = (x0_raw >= width_q)  ? width_q  - SW'(1) : x0_raw;
    y0_c   = (y0_raw >= height_q) ? height_q - SW'(1) : y0_raw;
    x0_inc = {1'b0, x0_c} + (SW+1)'(1);
    y0_inc = {1'b0, y0_c} + (SW+1)'(1);
    x1_c   = (x0_inc < {1'b0, width_q})  ? x0_inc[SW-1:0] : width_q  - SW'(1);
    y1_c   = (y0_inc < {1'b0, height_q}) ? y0_inc[SW-1:0] : height_q - SW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_COORD) begin
      x0_q    <= x0_c;
      x1_q    <= x1_c;
      base0_q <= IW'(y0_c) * IW'(width_q);
      base1_q <= IW'(y1_c) * IW'(width_q);
      fx_q    <= xf_q[15:8];
      fy_q    <= yf_q[15:8];
    end
  end

  // Read sequencing: one neighbor per cycle, in the order (x0,y0), (x1,y0),
  // (x0,y1), (x1,y1). Data is registered and returns in the cycle after its address.
  logic [1:0]    rd_cnt_q, rd_cnt_d;
  logic [1:0]    rd_prev;
  logic [IW-1:0] rd_idx;
  logic [31:0]   rd_idx_ext;
  logic          rd_oob_q;
  texel_t        rd_texel;
  texel_t        quad_q [3];

  assign rd_idx     = (rd_cnt_q[1] ? base1_q : base0_q) +
                      IW'(rd_cnt_q[0] ? x1_q : x0_q);
  assign rd_idx_ext = 32'(rd_idx);
  assign mem_raddr  = rd_idx_ext[AW-1:0];
  assign mem_re     = (state_q == S_READ);
  // An index past the store reads as zero.
  assign rd_texel   = rd_oob_q ? '0 : rdata_q;
  assign rd_prev    = rd_cnt_q - 2'd1;

  always_ff @(posedge clk_i) begin
    if (state_q == S_READ) begin
      rd_oob_q <= (rd_idx_ext >= 32'(MAX_TEXELS));
      if (rd_cnt_q != 2'd0) begin
        quad_q[rd_prev] <= rd_texel;
      end
    end
  end

  // Blend unit. It starts while the last texel is on the memory output.
  blend_req_t blend_req;
  logic       blend_start;
  logic       blend_done;
  texel_t     blend_color;

  assign blend_start        = (state_q == S_LAST);
  assign blend_req.fx       = fx_q;
  assign blend_req.fy       = fy_q;
  assign blend_req.texel[0] = quad_q[0];
  assign blend_req.texel[1] = quad_q[1];
  assign blend_req.texel[2] = quad_q[2];
  assign blend_req.texel[3] = rd_texel;

  bts_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (blend_start),
    .req_i   (blend_req),
    .done_o  (blend_done),
    .color_o (blend_color)
  );

  // ---------------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------------
  logic   out_valid_q, out_valid_d;
  texel_t out_data_q;
  logic   emit_fire;

  assign emit_fire = (state_q == S_EMIT) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    out_valid_d = out_valid_q && !m_axis_tready_i;
    if (emit_fire) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      out_data_q <= blend_color;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // ---------------------------------------------------------------------------
  // Control.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d  = state_q;
    rd_cnt_d = rd_cnt_q;
    case (state_q)
      S_IDLE: begin
        rd_cnt_d = 2'd0;
        if (s_fire && (s_axis_tuser_i == MODE_SAMPLE)) begin
          state_d = S_COORD;
        end
      end
      S_COORD: begin
        state_d = S_READ;
      end
      S_READ: begin
        rd_cnt_d = rd_cnt_q + 2'd1;
        if (rd_cnt_q == 2'd3) begin
          state_d = S_LAST;
        end
      end
      S_LAST: begin
        state_d = S_BLEND;
      end
      S_BLEND: begin
        if (blend_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (emit_fire) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rd_cnt_q    <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_cnt_q    <= rd_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[tb/bilinear_texture_sampler_rgb_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bilinear_texture_sampler_rgb_tb
// Self-checking bench for the bilinear RGB8 texture sampler. Texels are loaded
// and sampled through the input stream. Every accepted write updates a shadow
// texture, and every accepted sample predicts one filtered color. Each result
// transaction is checked channel by channel against the oldest prediction.
// The run steps through texture sizes that include the saturated and
// zero-sized extremes, and through several source and sink idling patterns.
// ----------------------------------------------------------------------------
module bilinear_texture_sampler_rgb_tb;
  import bts_pkg::*;

  // Bit positions of the coordinates inside the input tdata.
  localparam int unsigned U_LSB = ADDR_W + TEXEL_W;
  localparam int unsigned V_LSB = U_LSB + COORD_W;

  // Quiet stretch after the last result, longer than one sample occupies the
  // block, so that nothing is still in flight.
  localparam int unsigned DRAIN_CYCLES = 12;
  // The longest quiet stretch tolerated before the run is declared hung.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  // Samples also write their unwritten neighbors first, so the number of
  // input transactions is well above the number of actions on large textures.
  localparam int unsigned RANDOM_ITEMS_PER_PHASE = 65;
  localparam int unsigned PHASES = 8;

  // Shadow texture, size registers and the queue of predicted colors.
  class sampler_scoreboard;
    bit [TEXEL_W-1:0] texel_mem [MAX_TEXELS_DEFAULT];
    bit [CFG_DATA_W-1:0] width_reg = CFG_DATA_W'(TEX_SIDE_RESET);
    bit [CFG_DATA_W-1:0] height_reg = CFG_DATA_W'(TEX_SIDE_RESET);
    bit [TEXEL_W-1:0] colors_due [$];
    int unsigned mismatches = 0;

    // A side of zero counts as one, a side beyond the maximum saturates.
    function int unsigned fit_side(bit [CFG_DATA_W-1:0] side);
      if (side == 0) return 1;
      if (side > MAX_SIDE_DEFAULT) return MAX_SIDE_DEFAULT;
      return 32'(side);
    endfunction

    function void set_reg(bit [CFG_IDX_W-1:0] index, bit [CFG_DATA_W-1:0] value);
      case (index)
        REG_TEX_WIDTH: begin
          width_reg = value;
        end
        REG_TEX_HEIGHT: begin
          height_reg = value;
        end
        default: begin
        end
      endcase
    endfunction

    // Linear indexes of the four neighbors, in the order (x0,y0), (x1,y0),
    // (x0,y1), (x1,y1), together with the 8-bit blend weights.
    function void corners(input bit [COORD_W-1:0] u, input bit [COORD_W-1:0] v,
                          output int unsigned idx [4],
                          output int unsigned fx, output int unsigned fy);
      int unsigned w, h, xf, yf, x0, y0, x1, y1;
      w = fit_side(width_reg);
      h = fit_side(height_reg);
      xf = u * w;
      // The vertical axis is flipped: row = (1 - v) * height.
      yf = (32'(COORD_ONE) - v) * h;
      x0 = xf >> 16;
      y0 = yf >> 16;
      fx = (xf >> 8) & 32'hFF;
      fy = (yf >> 8) & 32'hFF;
      // With v at zero the row lands one past the bottom; pull it back.
      if (x0 > w - 1) x0 = w - 1;
      if (y0 > h - 1) y0 = h - 1;
      x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
      y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
      idx[0] = y0 * w + x0;
      idx[1] = y0 * w + x1;
      idx[2] = y1 * w + x0;
      idx[3] = y1 * w + x1;
    endfunction

    function bit [TEXEL_W-1:0] filter_color(bit [COORD_W-1:0] u, bit [COORD_W-1:0] v);
      int unsigned idx [4];
      int unsigned fx, fy, lo, hi, acc, chan;
      bit [TEXEL_W-1:0] color;
      corners(u, v, idx, fx, fy);
      for (int k = 0; k < CHANNELS; k++) begin
        lo = texel_mem[idx[0]][CH_W*k +: CH_W] * (WEIGHT_ONE - fx)
           + texel_mem[idx[1]][CH_W*k +: CH_W] * fx;
        hi = texel_mem[idx[2]][CH_W*k +: CH_W] * (WEIGHT_ONE - fx)
           + texel_mem[idx[3]][CH_W*k +: CH_W] * fx;
        acc = lo * (WEIGHT_ONE - fy) + hi * fy;
        chan = (acc + ROUND_HALF) >> 16;
        if (chan > 255) chan = 255;
        color[CH_W*k +: CH_W] = chan[CH_W-1:0];
      end
      return color;
    endfunction

    // Called for every accepted input transaction, in acceptance order.
    function void note_item(logic mode, logic [IN_DATA_W-1:0] data);
      if (mode == MODE_WRITE) begin
        texel_mem[data[ADDR_W-1:0]] = data[ADDR_W +: TEXEL_W];
      end else begin
        colors_due.push_back(filter_color(data[U_LSB +: COORD_W], data[V_LSB +: COORD_W]));
      end
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    // Called for every accepted result transaction.
    function void check_result(logic [TEXEL_W-1:0] got);
      bit [TEXEL_W-1:0] want;
      if (colors_due.size() == 0) begin
        flag($sformatf("%0t: color %h arrived with no sample outstanding", $time, got));
        return;
      end
      want = colors_due.pop_front();
      if (got[7:0] !== want[7:0] || got[15:8] !== want[15:8]
          || got[23:16] !== want[23:16]) begin
        flag($sformatf("%0t: color mismatch, expected r=%h g=%h b=%h, got r=%h g=%h b=%h",
                       $time, want[7:0], want[15:8], want[23:16],
                       got[7:0], got[15:8], got[23:16]));
      end
    endfunction

    function int unsigned pending();
      return colors_due.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_n = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = MODE_WRITE;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready = 1'b0;
  logic [TEXEL_W-1:0]    m_axis_tdata_o;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_TEX_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sampler_scoreboard sb = new();

  // Texels that the stimulus has written; a sample is only sent once all four
  // of its neighbors appear here, because the store is undefined until then.
  bit texel_written [MAX_TEXELS_DEFAULT];

  // Chance, in percent, that the source idles or the sink stalls in a cycle.
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned quiet_cycles = 0;

  bilinear_texture_sampler_rgb dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The sink side: ready is redrawn every cycle according to the stall rate.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Monitors. They run right after the rising edge, before any nonblocking
  // update of that edge lands, so they see the values the block saw.
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready_o) sb.set_reg(cfg_index, cfg_data);
      if (s_axis_tvalid && s_axis_tready_o) sb.note_item(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid_o && m_axis_tready) sb.check_result(m_axis_tdata_o);
    end
  end

  // Watchdog: the run is hung if no transaction of any kind completes for
  // too long.
  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((cfg_valid && cfg_ready_o) || (s_axis_tvalid && s_axis_tready_o)
          || (m_axis_tvalid_o && m_axis_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL bilinear_texture_sampler_rgb");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offers one input transaction and returns at the edge that accepts it.
  // Valid stays high into the next call unless that call starts with a gap.
  task automatic push_item(input logic mode, input logic [IN_DATA_W-1:0] data);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= data;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // The unused coordinate fields of a write carry noise.
  task automatic write_texel(input bit [ADDR_W-1:0] addr, input bit [TEXEL_W-1:0] rgb);
    texel_written[addr] = 1'b1;
    push_item(MODE_WRITE, {16'($urandom), 16'($urandom), rgb, addr});
  endtask

  // Fills any neighbor that has never been written, then sends the sample.
  // Its address and color fields carry noise.
  task automatic sample_at(input bit [COORD_W-1:0] u, input bit [COORD_W-1:0] v);
    int unsigned idx [4];
    int unsigned fx, fy;
    sb.corners(u, v, idx, fx, fy);
    for (int k = 0; k < 4; k++) begin
      if (!texel_written[idx[k]]) write_texel(ADDR_W'(idx[k]), 24'($urandom));
    end
    push_item(MODE_SAMPLE, {v, u, 24'($urandom), 16'($urandom)});
  endtask

  // One register write; valid is dropped for a cycle afterwards so that a
  // following write never lowers and raises it in the same time step.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits until every predicted color has been seen, then lets the block
  // settle. The first edge gives the monitor time to note the last input.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Mostly random coordinates, with both ends of the range mixed in now and then.
  function automatic bit [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // Half samples and half writes. Most writes land inside the current
  // texture so that samples see fresh data; the rest span the whole store.
  task automatic random_action();
    int unsigned span;
    bit [ADDR_W-1:0] addr;
    if ($urandom_range(0, 1) == 1) begin
      sample_at(pick_coord(), pick_coord());
    end else begin
      span = sb.fit_side(sb.width_reg) * sb.fit_side(sb.height_reg);
      if ($urandom_range(0, 4) == 0) addr = ADDR_W'($urandom);
      else addr = ADDR_W'($urandom_range(0, span - 1));
      write_texel(addr, 24'($urandom));
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] width_val, height_val;
    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    for (int p = 0; p < PHASES; p++) begin
      // Phase zero runs at the reset size, 256 by 256. Every later phase
      // changes the size while the block is idle.
      if (p > 0) begin
        wait_drained();
        case (p)
          1: begin width_val = 9'd1;   height_val = 9'd1;   end
          2: begin width_val = 9'd0;   height_val = 9'd0;   end // zero counts as one
          3: begin width_val = 9'd511; height_val = 9'd511; end // saturates to 256
          4: begin width_val = 9'd3;   height_val = 9'd5;   end
          5: begin width_val = 9'd256; height_val = 9'd1;   end
          6: begin width_val = 9'd1;   height_val = 9'd256; end
          default: begin
            width_val  = 9'($urandom_range(2, 64));
            height_val = 9'($urandom_range(2, 64));
          end
        endcase
        write_reg(REG_TEX_WIDTH, width_val);
        write_reg(REG_TEX_HEIGHT, height_val);
      end

      // Rotate through no idling, a slow source, a slow sink and light
      // idling on both sides.
      case (p % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 81; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 81; end
        default: begin src_idle_pct = 9; sink_stall_pct = 9; end
      endcase

      if (p == 0) begin
        // Full white next to full black, blended at the smallest vertical
        // fraction in the top left corner.
        write_texel(16'd0, 24'hFFFFFF);
        write_texel(16'd1, 24'h000000);
        write_texel(16'd256, 24'h00FF00);
        write_texel(16'd257, 24'hFF00FF);
        sample_at(16'h0000, 16'hFFFF);
        // v at zero puts the row on the far edge, clamped to the last row.
        sample_at(16'h0000, 16'h0000);
        // Right-hand column: the upper neighbor clamps to the last column.
        write_texel(16'hFFFF, 24'hFFFFFF);
        sample_at(16'hFFFF, 16'h0000);
        sample_at(16'hFFFF, 16'hFFFF);
        // The texture centre, then half-way weights in both directions.
        sample_at(16'h8000, 16'h8000);
        sample_at(16'h0080, 16'hFF80);
        // Overwriting a texel must change the next sample that reads it.
        write_texel(16'd0, 24'h123456);
        sample_at(16'h0000, 16'hFFFF);
      end

      repeat (RANDOM_ITEMS_PER_PHASE) random_action();
    end

    wait_drained();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS bilinear_texture_sampler_rgb");
    end else begin
      $display("FAIL bilinear_texture_sampler_rgb");
    end
    $finish;
  end

endmodule
